FILE: rtl/assert_macros.svh
// shared assertion macros for the bitmap shifter checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on clk, masked while rst is high
`define BMSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on clk, also checked across reset
`define BMSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bmsc_pkg.sv
// ----------------------------------------------------------------------------
// bmsc_pkg
// types and constants shared by the bitmap shifter with cloud layer
// ----------------------------------------------------------------------------
`default_nettype none

package bmsc_pkg;

  // request kinds on s_axis_tuser
  localparam logic OP_VIDEO     = 1'b0;
  localparam logic OP_ROM_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_CLOUD_ENABLE = 2'd0;
  localparam logic [1:0] CFG_FLIP         = 2'd1;
  localparam logic [1:0] CFG_SCROLL_POS   = 2'd2;

  // pixel colors
  localparam logic [1:0] COLOR_BLACK = 2'd0;
  localparam logic [1:0] COLOR_WHITE = 2'd1;
  localparam logic [1:0] COLOR_GREY  = 2'd2;

  // cloud rom geometry
  localparam int unsigned CLOUD_ROM_DEPTH = 2048;
  localparam int unsigned ROM_AW          = 11;
  localparam logic [7:0]  CLOUD_X_OFFSET  = 8'd12;

  localparam int unsigned PIXELS_PER_BYTE = 8;

  // one pixel as it sits in a cell
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] color;
    logic       last;
  } pixel_t;

  // what a cell receives when a new byte is loaded
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       video_bit;
    logic       cloud_bit;
    logic       last;
  } cell_load_t;

endpackage

`default_nettype wire

FILE: rtl/bmsc_cloud_rom.sv
// ----------------------------------------------------------------------------
// bmsc_cloud_rom
// cloud pattern store, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module bmsc_cloud_rom (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [bmsc_pkg::ROM_AW-1:0] waddr,
  input  wire logic [7:0]                  wdata,
  input  wire logic                        re,
  input  wire logic [bmsc_pkg::ROM_AW-1:0] raddr0,
  input  wire logic [bmsc_pkg::ROM_AW-1:0] raddr1,
  output logic      [7:0]                  rdata0,
  output logic      [7:0]                  rdata1
);

  logic [7:0] mem [bmsc_pkg::CLOUD_ROM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bmsc_cell.sv
// ----------------------------------------------------------------------------
// bmsc_cell
// one pixel cell of the output shift chain
// ----------------------------------------------------------------------------
`default_nettype none

module bmsc_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 shift,
  input  wire bmsc_pkg::cell_load_t ld,
  input  wire logic                 cloud_enable,
  input  wire logic                 flip,
  input  wire logic                 nb_valid,
  input  wire bmsc_pkg::pixel_t     nb_pix,
  output logic                      valid,
  output bmsc_pkg::pixel_t          pix
);

  bmsc_pkg::pixel_t ld_pix;

  // color pick and optional flip of a freshly loaded pixel
  always_comb begin
    ld_pix.x    = ld.x ^ {8{flip}};
    ld_pix.y    = ld.y ^ {8{flip}};
    ld_pix.last = ld.last;
    if (ld.video_bit) begin
      ld_pix.color = bmsc_pkg::COLOR_WHITE;
    end else if (cloud_enable && ld.cloud_bit) begin
      ld_pix.color = bmsc_pkg::COLOR_GREY;
    end else begin
      ld_pix.color = bmsc_pkg::COLOR_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix <= ld_pix;
    end else if (shift) begin
      pix <= nb_pix;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bitmap_shifter_with_cloud_layer_core.sv
// ----------------------------------------------------------------------------
// bitmap_shifter_with_cloud_layer_core
// turns video bytes into eight pixels each, with an optional grey cloud layer
// ----------------------------------------------------------------------------
// a request is held in the lookup stage, then loaded into the cells; cell 0 offers the first pixel
// one pixel per cycle while m_axis_tready holds, set by the eight-cell output chain that
//   hands one pixel per cycle to the result port; a new byte loads as the last pixel leaves
// rom write requests give no result
// reset (rst, synchronous) clears the config registers, the stage valid and the cell
//   valid bits; the cloud rom keeps its contents and needs no clearing pass
`default_nettype none

module bitmap_shifter_with_cloud_layer_core #(
  parameter int unsigned VIDEO_BYTES = 7168  // 32 .. 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // address[12:0], data[20:13], zero[23:21]
  input  wire logic        s_axis_tuser,  // opcode[0]
  // pixel stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // pixel_x[7:0], pixel_y[15:8], color[17:16], zero[23:18]
  output logic             m_axis_tlast   // last pixel of a byte
);

  localparam int unsigned NCELL = bmsc_pkg::PIXELS_PER_BYTE;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic       cloud_enable;
  logic       flip;
  logic [7:0] scroll_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      cloud_enable <= 1'b0;
      flip         <= 1'b0;
      scroll_pos   <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmsc_pkg::CFG_CLOUD_ENABLE: cloud_enable <= cfg_data[0];
        bmsc_pkg::CFG_FLIP:         flip         <= cfg_data[0];
        bmsc_pkg::CFG_SCROLL_POS:   scroll_pos   <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  logic [12:0] in_address;
  logic [7:0]  in_data;
  logic        accept;
  logic        vid_accept;
  logic        rom_write;

  assign in_address = s_axis_tdata[12:0];
  assign in_data    = s_axis_tdata[20:13];
  assign accept     = s_axis_tvalid && s_axis_tready;

  // video bytes past the end of the frame and rom writes past the rom are dropped
  assign vid_accept = accept && (s_axis_tuser == bmsc_pkg::OP_VIDEO)
                    && ({1'b0, in_address} < 14'(VIDEO_BYTES));
  assign rom_write  = accept && (s_axis_tuser == bmsc_pkg::OP_ROM_WRITE)
                    && ({1'b0, in_address} < 14'(bmsc_pkg::CLOUD_ROM_DEPTH));

  // ---------------------------------------------------------------------------
  // cloud lookup addresses
  // the eight pixels of a byte span cloud columns c0 .. c0+7, which may
  // straddle two rom bytes of the same row, so both are read at once
  // ---------------------------------------------------------------------------
  logic [7:0] in_y;
  logic [7:0] in_c0;
  logic [7:0] in_c7;
  logic [7:0] in_dy;
  logic [bmsc_pkg::ROM_AW-1:0] raddr0;
  logic [bmsc_pkg::ROM_AW-1:0] raddr1;

  assign in_y   = in_address[12:5];
  assign in_c0  = {in_address[4:0], 3'b000} - bmsc_pkg::CLOUD_X_OFFSET;
  assign in_c7  = in_c0 + 8'd7;
  assign in_dy  = in_y - scroll_pos;
  assign raddr0 = {in_dy[7:1], in_c0[7:4]};
  assign raddr1 = {in_dy[7:1], in_c7[7:4]};

  logic [7:0] rom_byte0;
  logic [7:0] rom_byte1;

  bmsc_cloud_rom u_rom (
    .clk    (clk),
    .we     (rom_write),
    .waddr  (in_address[bmsc_pkg::ROM_AW-1:0]),
    .wdata  (in_data),
    .re     (vid_accept),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rom_byte0),
    .rdata1 (rom_byte1)
  );

  // ---------------------------------------------------------------------------
  // lookup stage: holds one byte while the rom data arrives and the chain drains
  // ---------------------------------------------------------------------------
  logic        s1_valid;
  logic [12:0] s1_address;
  logic [7:0]  s1_data;
  logic [7:0]  s1_c0;
  logic        load;
  logic        shift;

  logic [NCELL-1:0]         cell_valid;
  bmsc_pkg::pixel_t         cell_pix [NCELL];

  // the chain takes a new byte when at most its head pixel is left and that one leaves now
  assign load  = s1_valid && !cell_valid[1] && (!cell_valid[0] || m_axis_tready);
  assign shift = !cell_valid[0] || m_axis_tready;

  // a request is taken while the stage is free or hands its byte on in this cycle
  assign s_axis_tready = !s1_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (vid_accept) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vid_accept) begin
      s1_address <= in_address;
      s1_data    <= in_data;
      s1_c0      <= in_c0;
    end
  end

  // ---------------------------------------------------------------------------
  // chain of pixel cells, cell 0 drives the pixel port
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [7:0]        cx;
    logic [7:0]        rom_byte;
    bmsc_pkg::cell_load_t ld;
    logic              nb_valid;
    bmsc_pkg::pixel_t  nb_pix;

    assign cx       = s1_c0 + 8'(i);
    // a cloud column in the same rom byte as the first pixel's reads the first rom byte
    assign rom_byte = (cx[7:4] == s1_c0[7:4]) ? rom_byte0 : rom_byte1;

    assign ld.x         = {s1_address[4:0], 3'(i)};
    assign ld.y         = s1_address[12:5];
    assign ld.video_bit = s1_data[i];
    assign ld.cloud_bit = rom_byte[cx[3:1]];
    assign ld.last      = (i == NCELL - 1);

    if (i == NCELL - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_pix   = '0;
    end else begin : g_body
      assign nb_valid = cell_valid[i+1];
      assign nb_pix   = cell_pix[i+1];
    end

    bmsc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .load         (load),
      .shift        (shift),
      .ld           (ld),
      .cloud_enable (cloud_enable),
      .flip         (flip),
      .nb_valid     (nb_valid),
      .nb_pix       (nb_pix),
      .valid        (cell_valid[i]),
      .pix          (cell_pix[i])
    );
  end

  // ---------------------------------------------------------------------------
  // pixel port
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = cell_valid[0];
  assign m_axis_tdata  = {6'b000000, cell_pix[0].color, cell_pix[0].y, cell_pix[0].x};
  assign m_axis_tlast  = cell_pix[0].last;

endmodule

`default_nettype wire

FILE: rtl/bmsc_checker.sv
// ----------------------------------------------------------------------------
// bmsc_checker
// port-level checks on the pixel stream of the bitmap shifter
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bmsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic       stalled;
  logic       tail;
  logic [2:0] col;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign tail    = m_axis_tvalid && m_axis_tlast;
  assign col     = m_axis_tdata[2:0];

  // a stalled pixel stays offered and unchanged
  `BMSC_ASSERT(a_stall_hold, stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "stall broken")

  // nothing is offered in the cycle after reset
  `BMSC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid, "pixel offered right after reset")

  // only black, white and grey exist
  `BMSC_ASSERT(a_color_code, m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3, "unknown color code")

  // the last pixel of a byte sits at the byte's end column, plain or flipped
  `BMSC_ASSERT(a_last_column, tail |-> col == 3'd7 || col == 3'd0, "last pixel at wrong column")

endmodule

bind bitmap_shifter_with_cloud_layer_core bmsc_checker u_bmsc_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives video bytes and cloud rom writes into the bitmap shifter and checks
// every pixel against a behavioral predictor or typed pixels: a directed table
// first, then random phases under several register settings with random stalls both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned VIDEO_BYTES  = 7168;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  // covers the pipeline plus margin before a register write or the end
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 15;
  localparam int unsigned PHASES       = 6;

  typedef enum logic [1:0] {ROW_REQ, ROW_CFG} row_kind_t;
  // how a directed row is checked: by the predictor, as giving no pixels,
  // or against the pixels typed into the row
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [1:0]  reg_index;
    logic [7:0]  reg_value;
    row_check_t  check;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [15:0] colors;  // color of bit 0 in the lowest two bits
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // address[12:0], data[20:13], zero[23:21]
  logic        s_axis_tuser;  // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // pixel_x[7:0], pixel_y[15:8], color[17:16], zero[23:18]
  logic        m_axis_tlast;

  // predictor state: shadow cloud rom, which entries hold data, registers
  logic [7:0]  rom_shadow [bmsc_pkg::CLOUD_ROM_DEPTH];
  bit          rom_written [bmsc_pkg::CLOUD_ROM_DEPTH];
  logic        cloud_on;
  logic        flip_on;
  logic [7:0]  cloud_scroll;

  bmsc_pkg::pixel_t pixels_due[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          tx_steady;
  bit          rx_steady;

  bitmap_shifter_with_cloud_layer_core #(
    .VIDEO_BYTES(VIDEO_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // rom entry under an unflipped pixel: row from the scrolled y, two lines
  // per rom row; column shifted left by the cloud offset, wrapping mod 256
  function automatic logic [10:0] cloud_index(logic [7:0] x, logic [7:0] y);
    logic [7:0] row2;
    logic [7:0] cx;
    row2 = y - cloud_scroll;
    cx   = x - bmsc_pkg::CLOUD_X_OFFSET;
    return {row2[7:1], cx[7:4]};
  endfunction

  function automatic logic cloud_at(logic [7:0] x, logic [7:0] y);
    logic [7:0] cx;
    cx = x - bmsc_pkg::CLOUD_X_OFFSET;
    return rom_shadow[cloud_index(x, y)][cx[3:1]];
  endfunction

  // sets every clear bit whose cloud lookup would land on a never written
  // rom entry, so the layer only ever looks at loaded data
  function automatic logic [7:0] cover_blank_rom(logic [12:0] addr, logic [7:0] data);
    logic [7:0] fixed;
    fixed = data;
    if (cloud_on && addr < VIDEO_BYTES)
      for (int i = 0; i < bmsc_pkg::PIXELS_PER_BYTE; i++)
        if (!rom_written[cloud_index({addr[4:0], i[2:0]}, addr[12:5])]) fixed[i] = 1'b1;
    return fixed;
  endfunction

  // applies one accepted request; queues its eight pixels when asked to
  task automatic predict_request(input logic op, input logic [12:0] addr,
                                 input logic [7:0] data, input bit keep);
    bmsc_pkg::pixel_t px;
    logic [7:0] x;
    logic [7:0] y;
    if (op == bmsc_pkg::OP_ROM_WRITE) begin
      // writes past the rom depth are dropped
      if (addr < bmsc_pkg::CLOUD_ROM_DEPTH) begin
        rom_shadow[addr[10:0]]  = data;
        rom_written[addr[10:0]] = 1'b1;
      end
    end else if (addr < VIDEO_BYTES && keep) begin
      for (int i = 0; i < bmsc_pkg::PIXELS_PER_BYTE; i++) begin
        x = {addr[4:0], i[2:0]};
        y = addr[12:5];
        // cloud lookup always on the unflipped coordinates
        if (data[i])                         px.color = bmsc_pkg::COLOR_WHITE;
        else if (cloud_on && cloud_at(x, y)) px.color = bmsc_pkg::COLOR_GREY;
        else                                 px.color = bmsc_pkg::COLOR_BLACK;
        px.x    = flip_on ? ~x : x;
        px.y    = flip_on ? ~y : y;
        px.last = (i == bmsc_pkg::PIXELS_PER_BYTE - 1);
        pixels_due.push_back(px);
      end
    end
  endtask

  // called right after a falling edge; returns at a falling edge with valid
  // still high unless a gap was taken
  task automatic send_request(input logic op, input logic [12:0] addr,
                              input logic [7:0] data, input bit keep);
    if (op == bmsc_pkg::OP_VIDEO) data = cover_blank_rom(addr, data);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {3'b000, data, addr};
    do @(posedge clk); while (!s_axis_tready);
    predict_request(op, addr, data, keep);
    @(negedge clk);
    if (!tx_steady && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  // registers change only with the pipeline empty
  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    s_axis_tvalid = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      bmsc_pkg::CFG_CLOUD_ENABLE: cloud_on     = value[0];
      bmsc_pkg::CFG_FLIP:         flip_on      = value[0];
      bmsc_pkg::CFG_SCROLL_POS:   cloud_scroll = value;
      default: ;
    endcase
  endtask

  function automatic stim_row_t request_row(logic op, logic [12:0] addr, logic [7:0] data,
                                            row_check_t check, logic [7:0] x0,
                                            logic [7:0] y0, logic [15:0] colors);
    stim_row_t row;
    row = '0;
    row.kind   = ROW_REQ;
    row.op     = op;
    row.addr   = addr;
    row.data   = data;
    row.check  = check;
    row.x0     = x0;
    row.y0     = y0;
    row.colors = colors;
    return row;
  endfunction

  // request row with no typed pixels
  function automatic stim_row_t plain_row(logic op, logic [12:0] addr, logic [7:0] data,
                                          row_check_t check);
    return request_row(op, addr, data, check, 8'd0, 8'd0, 16'd0);
  endfunction

  function automatic stim_row_t register_row(logic [1:0] index, logic [7:0] value);
    stim_row_t row;
    row = '0;
    row.kind      = ROW_CFG;
    row.reg_index = index;
    row.reg_value = value;
    return row;
  endfunction

  // receiver: runs of ready broken by stalls, none in steady phases
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!rx_steady) begin
        m_axis_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // pixel checker: each accepted pixel against the oldest expectation
  always @(posedge clk) begin : pixel_check
    bmsc_pkg::pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: x=%0d y=%0d color=%0d last=%0b",
                   m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[17:16],
                   m_axis_tlast);
      end else begin
        want = pixels_due.pop_front();
        if (m_axis_tdata[7:0] !== want.x || m_axis_tdata[15:8] !== want.y ||
            m_axis_tdata[17:16] !== want.color || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel wrong: expected x=%0d y=%0d color=%0d last=%0b, got x=%0d y=%0d color=%0d last=%0b",
                     want.x, want.y, want.color, want.last, m_axis_tdata[7:0],
                     m_axis_tdata[15:8], m_axis_tdata[17:16], m_axis_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_shifter_with_cloud_layer_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   rows[$];
    bmsc_pkg::pixel_t px;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [10:0] tile;
    int          pick;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = bmsc_pkg::CFG_CLOUD_ENABLE;
    cfg_data      = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 24'd0;
    s_axis_tuser  = bmsc_pkg::OP_VIDEO;
    cloud_on      = 1'b0;
    flip_on       = 1'b0;
    cloud_scroll  = 8'd0;
    mismatches    = 0;
    cycles        = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // cloud layer off: corners of the bitmap and the addresses past its end
    rows.push_back(register_row(bmsc_pkg::CFG_CLOUD_ENABLE, 8'd0));
    rows.push_back(request_row(bmsc_pkg::OP_VIDEO, 13'd0, 8'h00, CHK_TYPED, 8'd0, 8'd0,
                               {8{bmsc_pkg::COLOR_BLACK}}));
    rows.push_back(request_row(bmsc_pkg::OP_VIDEO, 13'd7167, 8'hff, CHK_TYPED, 8'd248,
                               8'd223, {8{bmsc_pkg::COLOR_WHITE}}));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd7168, 8'h55, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd8191, 8'haa, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd37, 8'ha5, CHK_MODEL));
    // rom loads at both ends, plus writes past the rom that must be dropped
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd0, 8'hff, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd2047, 8'hff, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd2048, 8'h00, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd8191, 8'h00, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd15, 8'h5a, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd16, 8'h3c, CHK_NONE));
    rows.push_back(plain_row(bmsc_pkg::OP_ROM_WRITE, 13'd2046, 8'hc3, CHK_NONE));
    // cloud on: left edge wraps the column into rom byte 15
    rows.push_back(register_row(bmsc_pkg::CFG_CLOUD_ENABLE, 8'd1));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd0, 8'h00, CHK_MODEL));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd1, 8'h0f, CHK_MODEL));
    rows.push_back(request_row(bmsc_pkg::OP_VIDEO, 13'd0, 8'hff, CHK_TYPED, 8'd0, 8'd0,
                               {8{bmsc_pkg::COLOR_WHITE}}));
    // scroll extremes, and the last rom row at the right edge
    rows.push_back(register_row(bmsc_pkg::CFG_SCROLL_POS, 8'd255));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd34, 8'h00, CHK_MODEL));
    rows.push_back(register_row(bmsc_pkg::CFG_SCROLL_POS, 8'd2));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd31, 8'h00, CHK_MODEL));
    // flipped output
    rows.push_back(register_row(bmsc_pkg::CFG_FLIP, 8'd1));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd31, 8'h0f, CHK_MODEL));
    rows.push_back(plain_row(bmsc_pkg::OP_VIDEO, 13'd7167, 8'hff, CHK_MODEL));

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        write_register(rows[r].reg_index, rows[r].reg_value);
      end else begin
        // typed pixels go in ahead of the request so they are never late
        if (rows[r].check == CHK_TYPED)
          for (int i = 0; i < bmsc_pkg::PIXELS_PER_BYTE; i++) begin
            px.x     = rows[r].x0 + i[7:0];
            px.y     = rows[r].y0;
            px.color = rows[r].colors[2*i +: 2];
            px.last  = (i == bmsc_pkg::PIXELS_PER_BYTE - 1);
            pixels_due.push_back(px);
          end
        send_request(rows[r].op, rows[r].addr, rows[r].data, rows[r].check == CHK_MODEL);
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(bmsc_pkg::CFG_CLOUD_ENABLE, 8'd0);
          write_register(bmsc_pkg::CFG_FLIP, 8'd0);
          write_register(bmsc_pkg::CFG_SCROLL_POS, 8'd0);
        end
        1: write_register(bmsc_pkg::CFG_CLOUD_ENABLE, 8'd1);
        2: write_register(bmsc_pkg::CFG_SCROLL_POS, 8'd255);
        3: begin
          write_register(bmsc_pkg::CFG_FLIP, 8'd1);
          write_register(bmsc_pkg::CFG_SCROLL_POS, 8'($urandom_range(0, 255)));
        end
        4: begin
          write_register(bmsc_pkg::CFG_CLOUD_ENABLE, 8'd0);
          write_register(bmsc_pkg::CFG_SCROLL_POS, 8'd255);
        end
        default: begin
          write_register(bmsc_pkg::CFG_CLOUD_ENABLE, 8'd1);
          write_register(bmsc_pkg::CFG_FLIP, 8'd0);
          write_register(bmsc_pkg::CFG_SCROLL_POS, 8'($urandom_range(0, 255)));
        end
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // in-range video byte, usually after loading the rom tiles it covers
          addr = 13'($urandom_range(0, VIDEO_BYTES - 1));
          case ($urandom_range(0, 7))
            0:       data = 8'h00;
            1:       data = 8'hff;
            default: data = 8'($urandom_range(0, 255));
          endcase
          if (cloud_on)
            for (int e = 0; e < 2; e++) begin
              tile = cloud_index({addr[4:0], 3'b000} + 8'(7 * e), addr[12:5]);
              if (!rom_written[tile] && $urandom_range(0, 3) != 0)
                send_request(bmsc_pkg::OP_ROM_WRITE, {2'b00, tile},
                             8'($urandom_range(0, 255)), 1'b1);
            end
          send_request(bmsc_pkg::OP_VIDEO, addr, data, 1'b1);
        end else if (pick < 72) begin
          send_request(bmsc_pkg::OP_VIDEO, 13'($urandom_range(VIDEO_BYTES, 8191)),
                       8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 92) begin
          send_request(bmsc_pkg::OP_ROM_WRITE,
                       13'($urandom_range(0, bmsc_pkg::CLOUD_ROM_DEPTH - 1)),
                       8'($urandom_range(0, 255)), 1'b1);
        end else begin
          send_request(bmsc_pkg::OP_ROM_WRITE,
                       13'($urandom_range(bmsc_pkg::CLOUD_ROM_DEPTH, 8191)),
                       8'($urandom_range(0, 255)), 1'b1);
        end
      end
    end

    // drain: everything expected, then a margin for strays
    s_axis_tvalid = 1'b0;
    tx_steady     = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("bitmap_shifter_with_cloud_layer_core: match");
    else
      $display("bitmap_shifter_with_cloud_layer_core: mismatch");
    $finish;
  end

endmodule
